// File: hw/rtl/read_request_cache_table_defines.svh
// Assertion macros for the read request cache table.
`ifndef READ_REQUEST_CACHE_TABLE_DEFINES_SVH
`define READ_REQUEST_CACHE_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define RRCT_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define RRCT_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define RRCT_ASSERT_IMP(label, clk, rst_n, a, b)
`define RRCT_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

// File: hw/rtl/rrct_pkg.sv
`timescale 1ns / 1ps
package rrct_pkg;
    localparam int SLOTS_DEF = 20;
    localparam int MAX_WORDS_DEF = 32;
    localparam int MAX_METERS_DEF = 8;
    localparam logic [3:0] METER_COUNT_RST = 4'd8;
    localparam logic [31:0] FRESH_WINDOW_RST = 32'd5000;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_CLAIM = 2'd1;
    localparam logic [1:0] CMD_STAGE = 2'd2;
    localparam logic [1:0] CMD_COMPLETE = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_INVALID = 3'd1;
    localparam logic [2:0] ST_NOT_READY = 3'd2;
    localparam logic [2:0] ST_NO_SPACE = 3'd3;
    localparam logic [2:0] ST_NONE_PENDING = 3'd4;
    localparam logic [2:0] ST_STALE = 3'd5;
    localparam logic [2:0] ST_ACCEPTED = 3'd6;

    localparam logic CFG_METER_COUNT = 1'b0;
    localparam logic CFG_FRESH_WINDOW = 1'b1;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] meter_id;
        logic [7:0] func_code;
        logic [15:0] address;
        logic [15:0] count;
        logic [31:0] now_ms;
        logic [4:0] slot;
        logic [31:0] generation;
        logic read_failed;
        logic [15:0] data_word;
        logic [5:0] word_index;
    } item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] slot_out;
        logic [31:0] generation_out;
        logic [7:0] meter_out;
        logic [7:0] function_out;
        logic [15:0] address_out;
        logic [6:0] count_out;
        logic [15:0] word_out;
        logic last;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_clear;
        logic scan_step;
        logic apply;
        logic copy_clear;
        logic copy_step;
        logic stream_clear;
        logic stream_step;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic copy_needed;
        logic copy_done;
        logic stream_needed;
        logic stream_done;
    } dp_stat_t;
endpackage

// File: hw/rtl/read_request_cache_table.sv
`timescale 1ns / 1ps
// Channel   Direction  Contents
// s_axis    in         one command item per transfer, the command in tuser
// m_axis    out        result items, the status in tuser, tlast on the final one
// cfg       in         register index and write data
// A command scans the table one slot at a time and then updates it in the APPLY state,
// and its result is valid once that update and any copy are done.
// The next transfer is accepted only once the result of the last has been taken.
// A successful completion adds a copy of key_count words from staging to cache.
// A fresh hit streams count words, one per cycle while m_axis_tready is high.
// Reset clears all slot state at once; s_axis_tready is high only while idle.
module read_request_cache_table #(
    parameter int SLOTS = rrct_pkg::SLOTS_DEF,
    parameter int MAX_WORDS = rrct_pkg::MAX_WORDS_DEF,
    parameter int MAX_METERS = rrct_pkg::MAX_METERS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // meter, function, address, count, now_ms, slot, generation,
    // read_failed, data_word, word_index, zero fill
    input  logic [143:0] s_axis_tdata,
    // command
    input  logic [1:0] s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // slot_out, generation_out, meter_out, function_out, address_out,
    // count_out, word_out, zero fill
    output logic [95:0] m_axis_tdata,
    // status
    output logic [2:0] m_axis_tuser,
    output logic m_axis_tlast,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic cfg_index,
    input  logic [31:0] cfg_data
);
    import rrct_pkg::*;

    item_t item;
    result_t res;
    dp_cmd_t cmd;
    dp_stat_t stat;

    assign item.command = s_axis_tuser;
    assign item.meter_id = s_axis_tdata[7:0];
    assign item.func_code = s_axis_tdata[15:8];
    assign item.address = s_axis_tdata[31:16];
    assign item.count = s_axis_tdata[47:32];
    assign item.now_ms = s_axis_tdata[79:48];
    assign item.slot = s_axis_tdata[84:80];
    assign item.generation = s_axis_tdata[116:85];
    assign item.read_failed = s_axis_tdata[117];
    assign item.data_word = s_axis_tdata[133:118];
    assign item.word_index = s_axis_tdata[139:134];

    assign cfg_ready = 1'b1;

    rrct_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_axis_tvalid),
        .s_tready(s_axis_tready),
        .res_ready(m_axis_tready),
        .res_valid(m_axis_tvalid),
        .cmd(cmd),
        .stat(stat)
    );

    rrct_datapath #(
        .SLOTS(SLOTS),
        .MAX_WORDS(MAX_WORDS),
        .MAX_METERS(MAX_METERS)
    ) u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .item(item),
        .cfg_we(cfg_valid && cfg_ready),
        .cfg_sel(cfg_index),
        .cfg_data(cfg_data),
        .cmd(cmd),
        .stat(stat),
        .result(res)
    );

    assign m_axis_tdata = {4'b0000, res.word_out, res.count_out, res.address_out,
        res.function_out, res.meter_out, res.generation_out, res.slot_out};
    assign m_axis_tuser = res.status;
    assign m_axis_tlast = res.last;
endmodule

// File: hw/rtl/rrct_ctrl.sv
`timescale 1ns / 1ps
`include "read_request_cache_table_defines.svh"
module rrct_ctrl (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic res_ready,
    output logic res_valid,
    output rrct_pkg::dp_cmd_t cmd,
    input  rrct_pkg::dp_stat_t stat
);
    import rrct_pkg::*;

    typedef enum logic [2:0] {
        IDLE, SCAN, APPLY, COPY, RESP, STREAM
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == IDLE);
    assign res_valid = (state_reg == RESP) || (state_reg == STREAM);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    cmd.scan_clear = 1'b1;
                    state_next = SCAN;
                end
            end
            SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = APPLY;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            APPLY:
            begin
                cmd.apply = 1'b1;
                cmd.copy_clear = 1'b1;
                cmd.stream_clear = 1'b1;
                if (stat.copy_needed)
                begin
                    state_next = COPY;
                end
                else if (stat.stream_needed)
                begin
                    state_next = STREAM;
                end
                else
                begin
                    state_next = RESP;
                end
            end
            COPY:
            begin
                cmd.copy_step = 1'b1;
                if (stat.copy_done)
                begin
                    state_next = RESP;
                end
            end
            RESP:
            begin
                if (res_ready)
                begin
                    state_next = IDLE;
                end
            end
            STREAM:
            begin
                if (res_ready)
                begin
                    cmd.stream_step = 1'b1;
                    if (stat.stream_done)
                    begin
                        state_next = IDLE;
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `RRCT_ASSERT_IMP(a_ready_idle, clk, rst_n, s_tready, !res_valid)
    `RRCT_ASSERT_NXT(a_accept_scan, clk, rst_n, s_tvalid && s_tready, state_reg == SCAN)
    `RRCT_ASSERT_IMP(a_one_copy, clk, rst_n, cmd.copy_step, !cmd.stream_step)
endmodule

// File: hw/rtl/rrct_datapath.sv
`timescale 1ns / 1ps
`include "read_request_cache_table_defines.svh"
module rrct_datapath #(
    parameter int SLOTS = rrct_pkg::SLOTS_DEF,
    parameter int MAX_WORDS = rrct_pkg::MAX_WORDS_DEF,
    parameter int MAX_METERS = rrct_pkg::MAX_METERS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  rrct_pkg::item_t item,
    input  logic cfg_we,
    input  logic cfg_sel,
    input  logic [31:0] cfg_data,
    input  rrct_pkg::dp_cmd_t cmd,
    output rrct_pkg::dp_stat_t stat,
    output rrct_pkg::result_t result
);
    import rrct_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CW = $clog2(MAX_WORDS + 1);
    localparam int SCW = $clog2(SLOTS + 1);
    localparam int MW = $clog2(SLOTS * MAX_WORDS);

    logic [3:0] meter_count_reg;
    logic [31:0] window_reg;

    logic [SLOTS-1:0] used_reg;
    logic [SLOTS-1:0] pend_reg;
    logic [SLOTS-1:0] busy_reg;
    logic [SLOTS-1:0] data_reg;
    logic [7:0] kmeter_reg [SLOTS];
    logic [7:0] kfunc_reg [SLOTS];
    logic [15:0] kaddr_reg [SLOTS];
    logic [CW-1:0] kcount_reg [SLOTS];
    logic [31:0] gen_reg [SLOTS];
    logic [31:0] req_reg [SLOTS];
    logic [31:0] upd_reg [SLOTS];

    logic [15:0] cache_mem [SLOTS * MAX_WORDS];
    logic [15:0] stage_mem [MAX_WORDS];

    item_t item_reg;
    logic [SCW-1:0] scan_reg;
    logic hit_found_reg;
    logic [SW-1:0] hit_reg;
    logic free_found_reg;
    logic [SW-1:0] free_reg;
    logic old_found_reg;
    logic [SW-1:0] old_reg;
    logic [31:0] oldest_reg;
    logic claim_found_reg;
    logic [SW-1:0] claim_reg;

    logic [CW-1:0] word_cnt_reg;
    logic [CW-1:0] word_len_reg;
    logic [SW-1:0] word_slot_reg;
    logic [15:0] stage_q_reg;
    logic copy_wr_reg;
    logic [WW-1:0] copy_wi_reg;
    logic [15:0] cache_q_reg;
    logic [2:0] status_reg;
    result_t claim_res_reg;
    result_t claim_res_next;
    logic stream_mode_reg;

    logic [SW-1:0] si;
    logic lk_invalid;
    logic [SW-1:0] cs;
    logic comp_ok;
    logic fresh;
    logic [31:0] age;

    assign si = scan_reg[SW-1:0];
    assign cs = item_reg.slot[SW-1:0];
    assign comp_ok = ({3'd0, item_reg.slot} < 8'(SLOTS)) && used_reg[cs]
        && (gen_reg[cs] == item_reg.generation);

    always_comb
    begin
        lk_invalid = ({4'd0, item_reg.meter_id} >= {8'd0, meter_count_reg})
            || ({1'b0, item_reg.meter_id} >= 9'(MAX_METERS))
            || !((item_reg.func_code == 8'd3) || (item_reg.func_code == 8'd4))
            || (item_reg.count == 16'd0) || (item_reg.count > 16'(MAX_WORDS));
        age = item_reg.now_ms - upd_reg[hit_reg];
        fresh = data_reg[hit_reg] && (age <= window_reg);
    end

    assign stat.scan_done = (scan_reg == SCW'(SLOTS));
    assign stat.copy_needed = (item_reg.command == CMD_COMPLETE) && comp_ok
        && !item_reg.read_failed;
    assign stat.stream_needed = (item_reg.command == CMD_LOOKUP) && !lk_invalid
        && hit_found_reg && fresh;
    assign stat.copy_done = (word_cnt_reg == word_len_reg);
    assign stat.stream_done = (word_cnt_reg + CW'(1) == word_len_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meter_count_reg <= METER_COUNT_RST;
            window_reg <= FRESH_WINDOW_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_sel == CFG_METER_COUNT)
            begin
                meter_count_reg <= cfg_data[3:0];
            end
            else
            begin
                window_reg <= cfg_data;
            end
        end
    end

    // Scan over slots, one slot per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.scan_clear)
        begin
            scan_reg <= '0;
            hit_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            old_found_reg <= 1'b0;
            claim_found_reg <= 1'b0;
            oldest_reg <= '1;
            hit_reg <= '0;
            free_reg <= '0;
            old_reg <= '0;
            claim_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            scan_reg <= scan_reg + SCW'(1);
            if (!hit_found_reg && used_reg[si] && kmeter_reg[si] == item_reg.meter_id
                && kfunc_reg[si] == item_reg.func_code
                && kaddr_reg[si] == item_reg.address
                && {{(16-CW){1'b0}}, kcount_reg[si]} == item_reg.count)
            begin
                hit_found_reg <= 1'b1;
                hit_reg <= si;
            end
            if (!free_found_reg)
            begin
                if (!used_reg[si])
                begin
                    free_found_reg <= 1'b1;
                    free_reg <= si;
                end
                else if (!busy_reg[si] && req_reg[si] <= oldest_reg)
                begin
                    old_found_reg <= 1'b1;
                    old_reg <= si;
                    oldest_reg <= req_reg[si];
                end
            end
            if (!claim_found_reg && used_reg[si] && pend_reg[si] && !busy_reg[si])
            begin
                claim_found_reg <= 1'b1;
                claim_reg <= si;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            pend_reg <= '0;
            busy_reg <= '0;
            data_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                kmeter_reg[i] <= '0;
                kfunc_reg[i] <= '0;
                kaddr_reg[i] <= '0;
                kcount_reg[i] <= '0;
                gen_reg[i] <= '0;
                req_reg[i] <= '0;
                upd_reg[i] <= '0;
            end
        end
        else if (cmd.apply)
        begin
            case (item_reg.command)
                CMD_LOOKUP:
                begin
                    if (!lk_invalid)
                    begin
                        if (hit_found_reg)
                        begin
                            req_reg[hit_reg] <= item_reg.now_ms;
                            if (!fresh)
                            begin
                                pend_reg[hit_reg] <= 1'b1;
                            end
                        end
                        else if (free_found_reg || old_found_reg)
                        begin
                            gen_reg[free_found_reg ? free_reg : old_reg] <=
                                gen_reg[free_found_reg ? free_reg : old_reg] + 32'd1;
                            used_reg[free_found_reg ? free_reg : old_reg] <= 1'b1;
                            pend_reg[free_found_reg ? free_reg : old_reg] <= 1'b1;
                            busy_reg[free_found_reg ? free_reg : old_reg] <= 1'b0;
                            data_reg[free_found_reg ? free_reg : old_reg] <= 1'b0;
                            kmeter_reg[free_found_reg ? free_reg : old_reg] <=
                                item_reg.meter_id;
                            kfunc_reg[free_found_reg ? free_reg : old_reg] <=
                                item_reg.func_code;
                            kaddr_reg[free_found_reg ? free_reg : old_reg] <= item_reg.address;
                            kcount_reg[free_found_reg ? free_reg : old_reg] <=
                                item_reg.count[CW-1:0];
                            req_reg[free_found_reg ? free_reg : old_reg] <= item_reg.now_ms;
                            upd_reg[free_found_reg ? free_reg : old_reg] <= '0;
                        end
                    end
                end
                CMD_CLAIM:
                begin
                    if (claim_found_reg)
                    begin
                        pend_reg[claim_reg] <= 1'b0;
                        busy_reg[claim_reg] <= 1'b1;
                    end
                end
                CMD_COMPLETE:
                begin
                    if (comp_ok)
                    begin
                        busy_reg[cs] <= 1'b0;
                        if (!item_reg.read_failed)
                        begin
                            data_reg[cs] <= 1'b1;
                            upd_reg[cs] <= item_reg.now_ms;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        claim_res_next = '0;
        if ((item_reg.command == CMD_CLAIM) && claim_found_reg)
        begin
            claim_res_next.slot_out = 5'(claim_reg);
            claim_res_next.generation_out = gen_reg[claim_reg];
            claim_res_next.meter_out = kmeter_reg[claim_reg];
            claim_res_next.function_out = kfunc_reg[claim_reg];
            claim_res_next.address_out = kaddr_reg[claim_reg];
            claim_res_next.count_out = 7'(kcount_reg[claim_reg]);
        end
    end

    // Status and claim fields of the result, shared by every word of a stream.
    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            claim_res_reg <= claim_res_next;
            stream_mode_reg <= stat.stream_needed;
            case (item_reg.command)
                CMD_LOOKUP:
                begin
                    if (lk_invalid)
                    begin
                        status_reg <= ST_INVALID;
                    end
                    else if (hit_found_reg)
                    begin
                        status_reg <= fresh ? ST_OK
                            : (data_reg[hit_reg] ? ST_STALE : ST_NOT_READY);
                    end
                    else if (free_found_reg || old_found_reg)
                    begin
                        status_reg <= ST_NOT_READY;
                    end
                    else
                    begin
                        status_reg <= ST_NO_SPACE;
                    end
                end
                CMD_CLAIM:
                begin
                    status_reg <= claim_found_reg ? ST_ACCEPTED : ST_NONE_PENDING;
                end
                CMD_STAGE:
                begin
                    status_reg <= ({26'd0, item_reg.word_index} < 32'(MAX_WORDS))
                        ? ST_ACCEPTED : ST_INVALID;
                end
                default:
                begin
                    status_reg <= comp_ok ? ST_ACCEPTED : ST_INVALID;
                end
            endcase
        end
    end

    // Word counter for the copy and the stream, one word per cycle, the stream only while the result is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_cnt_reg <= '0;
            word_len_reg <= '0;
            word_slot_reg <= '0;
            copy_wr_reg <= 1'b0;
            copy_wi_reg <= '0;
        end
        else
        begin
            copy_wr_reg <= cmd.copy_step && !stat.copy_done;
            copy_wi_reg <= word_cnt_reg[WW-1:0];
            if (cmd.apply)
            begin
                word_cnt_reg <= '0;
                word_slot_reg <= stat.copy_needed ? cs : hit_reg;
                word_len_reg <= stat.copy_needed ? kcount_reg[cs] : item_reg.count[CW-1:0];
            end
            else if ((cmd.copy_step && !stat.copy_done) || cmd.stream_step)
            begin
                word_cnt_reg <= word_cnt_reg + CW'(1);
            end
        end
    end

    logic [CW-1:0] rd_idx;
    assign rd_idx = cmd.stream_step ? word_cnt_reg + CW'(1) : word_cnt_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load && item.command == CMD_STAGE
            && {26'd0, item.word_index} < 32'(MAX_WORDS))
        begin
            stage_mem[item.word_index[WW-1:0]] <= item.data_word;
        end
        stage_q_reg <= stage_mem[word_cnt_reg[WW-1:0]];
        if (copy_wr_reg)
        begin
            cache_mem[MW'(word_slot_reg) * MW'(MAX_WORDS) + MW'(copy_wi_reg)] <= stage_q_reg;
        end
        cache_q_reg <= cache_mem[MW'(cmd.apply ? hit_reg : word_slot_reg) * MW'(MAX_WORDS)
            + MW'(cmd.apply ? CW'(0) : rd_idx)];
    end

    always_comb
    begin
        result = claim_res_reg;
        result.status = status_reg;
        result.word_out = stream_mode_reg ? cache_q_reg : 16'd0;
        result.last = stream_mode_reg ? stat.stream_done : 1'b1;
    end

    `RRCT_ASSERT_IMP(a_copy_stop, clk, rst_n, cmd.copy_step, word_cnt_reg <= word_len_reg)
    `RRCT_ASSERT_IMP(a_stream_bound, clk, rst_n, cmd.stream_step, word_cnt_reg < word_len_reg)
    `RRCT_ASSERT_IMP(a_scan_bound, clk, rst_n, cmd.scan_step, scan_reg < SCW'(SLOTS))
endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
module tb;
    import rrct_pkg::*;

    class job_table_predictor;
        logic [3:0] meter_count;
        logic [31:0] fresh_window;
        bit used [SLOTS_DEF];
        bit pending [SLOTS_DEF];
        bit busy [SLOTS_DEF];
        bit filled [SLOTS_DEF];
        logic [7:0] k_meter [SLOTS_DEF];
        logic [7:0] k_function [SLOTS_DEF];
        logic [15:0] k_address [SLOTS_DEF];
        logic [5:0] k_count [SLOTS_DEF];
        logic [31:0] gen [SLOTS_DEF];
        logic [31:0] req_time [SLOTS_DEF];
        logic [31:0] upd_time [SLOTS_DEF];
        logic [15:0] cache [SLOTS_DEF][MAX_WORDS_DEF];
        logic [15:0] staging [MAX_WORDS_DEF];
        result_t awaited [$];
        int errors;
        int words_seen;

        function new();
            meter_count = METER_COUNT_RST;
            fresh_window = FRESH_WINDOW_RST;
            errors = 0;
            words_seen = 0;
            for (int i = 0; i < SLOTS_DEF; i++)
            begin
                used[i] = 0;
                pending[i] = 0;
                busy[i] = 0;
                filled[i] = 0;
                k_meter[i] = '0;
                k_function[i] = '0;
                k_address[i] = '0;
                k_count[i] = '0;
                gen[i] = '0;
                req_time[i] = '0;
                upd_time[i] = '0;
            end
        endfunction

        function void set_register(logic idx, logic [31:0] value);
            if (idx == CFG_METER_COUNT)
                meter_count = value[3:0];
            else
                fresh_window = value;
        endfunction

        function void push_single(logic [2:0] st);
            result_t r;
            r = '0;
            r.status = st;
            r.last = 1'b1;
            awaited.push_back(r);
        endfunction

        function void lookup(item_t it);
            int hit;
            int pick;
            logic [31:0] oldest;
            result_t r;
            hit = -1;
            pick = -1;
            oldest = 32'hFFFF_FFFF;
            if (it.meter_id >= meter_count || it.meter_id >= MAX_METERS_DEF ||
                (it.func_code != 8'd3 && it.func_code != 8'd4) ||
                it.count == 0 || it.count > MAX_WORDS_DEF)
            begin
                push_single(ST_INVALID);
                return;
            end
            for (int i = 0; i < SLOTS_DEF; i++)
            begin
                if (used[i] && k_meter[i] == it.meter_id && k_function[i] == it.func_code
                    && k_address[i] == it.address && k_count[i] == it.count)
                begin
                    hit = i;
                    break;
                end
            end
            if (hit >= 0)
            begin
                req_time[hit] = it.now_ms;
                if (filled[hit] && (it.now_ms - upd_time[hit]) <= fresh_window)
                begin
                    for (int i = 0; i < it.count; i++)
                    begin
                        r = '0;
                        r.status = ST_OK;
                        r.word_out = cache[hit][i];
                        r.last = (i + 1 == it.count);
                        awaited.push_back(r);
                    end
                    return;
                end
                pending[hit] = 1;
                push_single(filled[hit] ? ST_STALE : ST_NOT_READY);
                return;
            end
            for (int i = 0; i < SLOTS_DEF; i++)
            begin
                if (!used[i])
                begin
                    pick = i;
                    break;
                end
                if (!busy[i] && req_time[i] <= oldest)
                begin
                    oldest = req_time[i];
                    pick = i;
                end
            end
            if (pick < 0)
            begin
                push_single(ST_NO_SPACE);
                return;
            end
            gen[pick] = gen[pick] + 32'd1;
            used[pick] = 1;
            pending[pick] = 1;
            busy[pick] = 0;
            filled[pick] = 0;
            k_meter[pick] = it.meter_id;
            k_function[pick] = it.func_code;
            k_address[pick] = it.address;
            k_count[pick] = it.count[5:0];
            req_time[pick] = it.now_ms;
            upd_time[pick] = '0;
            push_single(ST_NOT_READY);
        endfunction

        function void note_input(item_t it);
            result_t r;
            case (it.command)
                CMD_LOOKUP: lookup(it);
                CMD_CLAIM:
                begin
                    for (int i = 0; i < SLOTS_DEF; i++)
                    begin
                        if (used[i] && pending[i] && !busy[i])
                        begin
                            pending[i] = 0;
                            busy[i] = 1;
                            r = '0;
                            r.status = ST_ACCEPTED;
                            r.slot_out = 5'(i);
                            r.generation_out = gen[i];
                            r.meter_out = k_meter[i];
                            r.function_out = k_function[i];
                            r.address_out = k_address[i];
                            r.count_out = {1'b0, k_count[i]};
                            r.last = 1'b1;
                            awaited.push_back(r);
                            return;
                        end
                    end
                    push_single(ST_NONE_PENDING);
                end
                CMD_STAGE:
                begin
                    if (it.word_index >= MAX_WORDS_DEF)
                        push_single(ST_INVALID);
                    else
                    begin
                        staging[it.word_index] = it.data_word;
                        push_single(ST_ACCEPTED);
                    end
                end
                default:
                begin
                    if (it.slot >= SLOTS_DEF || !used[it.slot] || gen[it.slot] != it.generation)
                        push_single(ST_INVALID);
                    else
                    begin
                        busy[it.slot] = 0;
                        if (!it.read_failed)
                        begin
                            for (int i = 0; i < k_count[it.slot] && i < MAX_WORDS_DEF; i++)
                                cache[it.slot][i] = staging[i];
                            filled[it.slot] = 1;
                            upd_time[it.slot] = it.now_ms;
                        end
                        push_single(ST_ACCEPTED);
                    end
                end
            endcase
        endfunction

        function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(logic [2:0] u, logic [95:0] d, logic l);
            result_t e;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, got %h user %h last %b",
                         $time, d, u, l);
                return;
            end
            e = awaited.pop_front();
            if (e.status == ST_OK)
                words_seen++;
            compare("status", 32'(e.status), 32'(u));
            compare("slot_out", 32'(e.slot_out), 32'(d[4:0]));
            compare("generation_out", e.generation_out, d[36:5]);
            compare("meter_out", 32'(e.meter_out), 32'(d[44:37]));
            compare("function_out", 32'(e.function_out), 32'(d[52:45]));
            compare("address_out", 32'(e.address_out), 32'(d[68:53]));
            compare("count_out", 32'(e.count_out), 32'(d[75:69]));
            compare("word_out", 32'(e.word_out), 32'(d[91:76]));
            compare("fill", 32'd0, 32'(d[95:92]));
            compare("last", 32'(e.last), 32'(l));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [143:0] s_axis_tdata = '0;
    logic [1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;
    logic m_axis_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;

    job_table_predictor table_model = new();
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_cycles = 0;
    bit hold_req = 0;
    int items_sent = 0;
    logic [31:0] now_ms = 32'd1000;

    read_request_cache_table uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 0;
            hold_cycles = 400;
        end
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            table_model.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end

    task automatic send(item_t it);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.command;
        s_axis_tdata <= {4'b0000, it.word_index, it.data_word, it.read_failed, it.generation,
                         it.slot, it.now_ms, it.count, it.address, it.func_code,
                         it.meter_id};
        do
            @(posedge clk);
        while (!s_axis_tready);
        table_model.note_input(it);
        items_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (table_model.awaited.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_register(logic idx, logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        table_model.set_register(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic item_t noise_item();
        item_t it;
        it.command = 2'($urandom_range(3));
        it.meter_id = 8'($urandom);
        it.func_code = 8'($urandom);
        it.address = 16'($urandom);
        it.count = 16'($urandom);
        it.now_ms = $urandom;
        it.slot = 5'($urandom);
        it.generation = $urandom;
        it.read_failed = 1'($urandom);
        it.data_word = 16'($urandom);
        it.word_index = 6'($urandom);
        return it;
    endfunction

    function automatic item_t lookup_item(logic [7:0] m, logic [7:0] f, logic [15:0] a,
                                          logic [15:0] c);
        item_t it;
        it = noise_item();
        it.command = CMD_LOOKUP;
        it.meter_id = m;
        it.func_code = f;
        it.address = a;
        it.count = c;
        it.now_ms = now_ms;
        return it;
    endfunction

    function automatic item_t pool_lookup();
        logic [15:0] counts [5] = '{16'd1, 16'd2, 16'd3, 16'd8, 16'd32};
        logic [15:0] addrs [4] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h1234};
        return lookup_item(8'($urandom_range(7)), $urandom_range(1) ? 8'd3 : 8'd4,
                           addrs[$urandom_range(3)], counts[$urandom_range(4)]);
    endfunction

    function automatic item_t simple_item(logic [1:0] cmd);
        item_t it;
        it = noise_item();
        it.command = cmd;
        it.now_ms = now_ms;
        return it;
    endfunction

    function automatic item_t complete_item(bit fail);
        item_t it;
        int s;
        it = simple_item(CMD_COMPLETE);
        it.read_failed = fail;
        s = -1;
        for (int i = 0; i < SLOTS_DEF; i++)
        begin
            if (table_model.busy[i] && s < 0)
                s = i;
        end
        if (s < 0)
            s = $urandom_range(SLOTS_DEF - 1);
        it.slot = 5'(s);
        it.generation = table_model.gen[s];
        return it;
    endfunction

    task automatic job_round();
        item_t key;
        int n;
        key = pool_lookup();
        now_ms = now_ms + $urandom_range(3000);
        key.now_ms = now_ms;
        send(key);
        send(simple_item(CMD_CLAIM));
        n = $urandom_range(2);
        for (int i = 0; i < n; i++)
        begin
            item_t st;
            st = simple_item(CMD_STAGE);
            st.word_index = 6'($urandom_range(MAX_WORDS_DEF - 1));
            send(st);
        end
        now_ms = now_ms + $urandom_range(200);
        send(complete_item($urandom_range(9) == 0));
        now_ms = now_ms + ($urandom_range(3) == 0 ? $urandom_range(20000) : $urandom_range(500));
        key.now_ms = now_ms;
        send(key);
    endtask

    task automatic random_phase(int count);
        int start;
        start = items_sent;
        while (items_sent - start < count)
        begin
            case ($urandom_range(9))
                0, 1: send(noise_item());
                2: send(simple_item(CMD_CLAIM));
                3: send(complete_item(1'($urandom_range(1))));
                default: job_round();
            endcase
        end
    endtask

    initial
    begin
        item_t it;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < MAX_WORDS_DEF; i++)
        begin
            it = simple_item(CMD_STAGE);
            it.word_index = 6'(i);
            it.data_word = (i == 0) ? 16'hFFFF : (i == 1) ? 16'h0000 : 16'($urandom);
            send(it);
        end
        it = simple_item(CMD_STAGE);
        it.word_index = 6'd63;
        send(it);
        send(simple_item(CMD_CLAIM));
        send(lookup_item(8'd8, 8'd3, 16'h0, 16'd1));
        send(lookup_item(8'd255, 8'd3, 16'h0, 16'd1));
        send(lookup_item(8'd0, 8'd5, 16'h0, 16'd1));
        send(lookup_item(8'd0, 8'd3, 16'h0, 16'd0));
        send(lookup_item(8'd0, 8'd3, 16'h0, 16'd33));
        send(lookup_item(8'd0, 8'd3, 16'h0, 16'hFFFF));
        send(lookup_item(8'd7, 8'd4, 16'hFFFF, 16'd32));
        send(lookup_item(8'd7, 8'd4, 16'hFFFF, 16'd32));
        send(simple_item(CMD_CLAIM));
        it = complete_item(0);
        it.generation = it.generation + 32'd1;
        send(it);
        it = simple_item(CMD_COMPLETE);
        it.slot = 5'd31;
        send(it);
        now_ms = now_ms + 10;
        send(complete_item(0));
        send(lookup_item(8'd7, 8'd4, 16'hFFFF, 16'd32));
        now_ms = now_ms + 5001;
        send(lookup_item(8'd7, 8'd4, 16'hFFFF, 16'd32));
        send(lookup_item(8'd0, 8'd3, 16'd5, 16'd1));
        drain();

        // Fill every slot with a busy job so the next miss finds no room.
        for (int i = 0; i < SLOTS_DEF; i++)
        begin
            send(lookup_item(8'd1, 8'd3, 16'(100 + i), 16'd2));
            send(simple_item(CMD_CLAIM));
        end
        send(lookup_item(8'd2, 8'd4, 16'd7, 16'd2));
        for (int i = 0; i < SLOTS_DEF; i++)
        begin
            now_ms = now_ms + $urandom_range(1);
            send(complete_item(1'($urandom_range(1))));
        end
        drain();

        idle_pct = 72;
        stall_pct = 0;
        write_register(CFG_FRESH_WINDOW, 32'hFFFF_FFFF);
        write_register(CFG_METER_COUNT, 32'd0);
        random_phase(4);
        drain();
        write_register(CFG_METER_COUNT, 32'd3);
        now_ms = 32'hFFFF_F000;
        random_phase(12);
        drain();

        idle_pct = 0;
        stall_pct = 72;
        write_register(CFG_FRESH_WINDOW, 32'd0);
        write_register(CFG_METER_COUNT, 32'd8);
        random_phase(8);
        hold_req = 1;
        random_phase(6);
        drain();

        idle_pct = 24;
        stall_pct = 24;
        write_register(CFG_FRESH_WINDOW, 32'd2500);
        write_register(CFG_METER_COUNT, 32'd5);
        random_phase(14);
        drain();

        idle_pct = 0;
        stall_pct = 0;
        write_register(CFG_FRESH_WINDOW, FRESH_WINDOW_RST);
        write_register(CFG_METER_COUNT, 32'd8);
        random_phase(14);
        drain();

        $display("Covered %0d input transfers, %0d cached words streamed,", items_sent,
                 table_model.words_seen);
        $display("five register settings, full table, stale and wrapped time cases.");
        if (table_model.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("Timeout with %0d results outstanding", table_model.awaited.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
